FILE: rtl/core/csl_pkg.sv
// Shared types and constants of the color sorting line controller.
package csl_pkg;

  localparam int unsigned ColorW = 14;
  localparam int unsigned DistW  = 5;
  localparam int unsigned TicksW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ColorW-1:0] COLOR_START = ColorW'(10000);
  localparam logic [DistW-1:0]  EDGE_MAX    = DistW'(31);

  localparam logic [ColorW-1:0] WHITE_THRESHOLD_RST = ColorW'(2500);
  localparam logic [ColorW-1:0] RED_THRESHOLD_RST   = ColorW'(4600);
  localparam logic [DistW-1:0]  WHITE_DISTANCE_RST  = DistW'(3);
  localparam logic [DistW-1:0]  RED_DISTANCE_RST    = DistW'(9);
  localparam logic [DistW-1:0]  BLUE_DISTANCE_RST   = DistW'(14);
  localparam logic [TicksW-1:0] EJECT_TICKS_RST     = TicksW'(1500);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHITE_THRESHOLD = 3'd0,
    CFG_RED_THRESHOLD   = 3'd1,
    CFG_WHITE_DISTANCE  = 3'd2,
    CFG_RED_DISTANCE    = 3'd3,
    CFG_BLUE_DISTANCE   = 3'd4,
    CFG_EJECT_TICKS     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_WAITING = 2'd0,
    MODE_SENSING = 2'd1,
    MODE_MOVE    = 2'd2,
    MODE_EJECT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLASS_WHITE = 2'd0,
    CLASS_RED   = 2'd1,
    CLASS_BLUE  = 2'd2
  } part_class_t;

  typedef struct packed {
    logic [ColorW-1:0] white_threshold;
    logic [ColorW-1:0] red_threshold;
    logic [DistW-1:0]  white_distance;
    logic [DistW-1:0]  red_distance;
    logic [DistW-1:0]  blue_distance;
    logic [TicksW-1:0] eject_ticks;
  } cfg_t;

  typedef struct packed {
    logic              inlet_barrier_level;
    logic              outlet_barrier_level;
    logic              pulse_key_level;
    logic [ColorW-1:0] color_sample;
    logic              white_slot_level;
    logic              red_slot_level;
    logic              blue_slot_level;
  } sample_t;

  typedef struct packed {
    logic       conveyor_on;
    logic       compressor_on;
    logic       eject_white;
    logic       eject_red;
    logic       eject_blue;
    logic       robot_white_ready;
    logic       robot_red_ready;
    logic       robot_blue_ready;
    logic [1:0] phase;
  } result_t;

endpackage

FILE: rtl/core/color_sorting_line_controller.sv
// Color sorting line controller top level: config port, sequencer, result register.
// The result of an item is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle; the result register is reloaded in the cycle it is taken,
// so sample_stall rises only while a held result is stalled downstream.
// Reset (rst, synchronous): waiting mode, outputs off, registers at their defaults.
module color_sorting_line_controller
  import csl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_t             sample,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  result_t result_next;
  logic    step;

  assign cfg_ready    = 1'b1;
  assign sample_stall = result_valid & result_stall;
  assign step         = sample_valid & ~sample_stall;

  csl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .sample      (sample),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/core/csl_cfg.sv
// Configuration register file: thresholds, travel distances and eject time.
module csl_cfg
  import csl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.white_threshold <= WHITE_THRESHOLD_RST;
      cfg.red_threshold   <= RED_THRESHOLD_RST;
      cfg.white_distance  <= WHITE_DISTANCE_RST;
      cfg.red_distance    <= RED_DISTANCE_RST;
      cfg.blue_distance   <= BLUE_DISTANCE_RST;
      cfg.eject_ticks     <= EJECT_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WHITE_THRESHOLD: cfg.white_threshold <= cfg_data[ColorW-1:0];
        CFG_RED_THRESHOLD:   cfg.red_threshold   <= cfg_data[ColorW-1:0];
        CFG_WHITE_DISTANCE:  cfg.white_distance  <= cfg_data[DistW-1:0];
        CFG_RED_DISTANCE:    cfg.red_distance    <= cfg_data[DistW-1:0];
        CFG_BLUE_DISTANCE:   cfg.blue_distance   <= cfg_data[DistW-1:0];
        CFG_EJECT_TICKS:     cfg.eject_ticks     <= cfg_data[TicksW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

FILE: rtl/core/csl_ctrl.sv
// Sorting sequencer: mode register, color minimum, edge counter and eject timer.
module csl_ctrl
  import csl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result_next
);

  mode_t             mode, mode_next;
  logic [ColorW-1:0] min_color, min_color_next;
  logic [DistW-1:0]  target_distance, target_distance_next;
  part_class_t       part_class, part_class_next;
  logic [DistW-1:0]  edges_counted, edges_counted_next;
  logic              previous_key, previous_key_next;
  logic [TicksW-1:0] eject_timer, eject_timer_next;
  logic              conveyor_reg, conveyor_reg_next;
  logic              compressor_reg, compressor_reg_next;

  logic [ColorW-1:0] min_seen;
  logic [TicksW-1:0] timer_inc;
  logic              ew, er, eb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_WAITING;
      min_color       <= COLOR_START;
      target_distance <= '0;
      part_class      <= CLASS_BLUE;
      edges_counted   <= '0;
      previous_key    <= 1'b0;
      eject_timer     <= '0;
      conveyor_reg    <= 1'b0;
      compressor_reg  <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      min_color       <= min_color_next;
      target_distance <= target_distance_next;
      part_class      <= part_class_next;
      edges_counted   <= edges_counted_next;
      previous_key    <= previous_key_next;
      eject_timer     <= eject_timer_next;
      conveyor_reg    <= conveyor_reg_next;
      compressor_reg  <= compressor_reg_next;
    end
  end

  always_comb begin
    mode_next            = mode;
    min_color_next       = min_color;
    target_distance_next = target_distance;
    part_class_next      = part_class;
    edges_counted_next   = edges_counted;
    previous_key_next    = previous_key;
    eject_timer_next     = eject_timer;
    conveyor_reg_next    = conveyor_reg;
    compressor_reg_next  = compressor_reg;
    ew = 1'b0;
    er = 1'b0;
    eb = 1'b0;
    min_seen  = (sample.color_sample < min_color) ? sample.color_sample : min_color;
    timer_inc = eject_timer + TicksW'(1);

    unique case (mode)
      MODE_WAITING: begin
        if (!sample.inlet_barrier_level) begin
          mode_next         = MODE_SENSING;
          conveyor_reg_next = 1'b1;
          min_color_next    = COLOR_START;
        end
      end
      MODE_SENSING: begin
        min_color_next = min_seen;
        if (!sample.outlet_barrier_level) begin
          mode_next           = MODE_MOVE;
          edges_counted_next  = '0;
          compressor_reg_next = 1'b1;
          // classify on the minimum including this tick's sample
          if (min_seen < cfg.white_threshold) begin
            target_distance_next = cfg.white_distance;
            part_class_next      = CLASS_WHITE;
          end else if (min_seen < cfg.red_threshold) begin
            target_distance_next = cfg.red_distance;
            part_class_next      = CLASS_RED;
          end else begin
            target_distance_next = cfg.blue_distance;
            part_class_next      = CLASS_BLUE;
          end
        end
      end
      MODE_MOVE: begin
        if (sample.pulse_key_level && !previous_key && edges_counted != EDGE_MAX) begin
          edges_counted_next = edges_counted + DistW'(1);
        end
        previous_key_next = sample.pulse_key_level;
        if (edges_counted_next >= target_distance) begin
          mode_next         = MODE_EJECT;
          conveyor_reg_next = 1'b0;
          eject_timer_next  = '0;
        end
      end
      MODE_EJECT: begin
        case (part_class)
          CLASS_WHITE: ew = 1'b1;
          CLASS_RED:   er = 1'b1;
          default:     eb = 1'b1;
        endcase
        eject_timer_next = timer_inc;
        // the >= compare covers eject_ticks of zero; a wrapped timer also ends the hold
        if (timer_inc == '0 || timer_inc >= cfg.eject_ticks) begin
          mode_next        = MODE_WAITING;
          eject_timer_next = '0;
        end
      end
      default: mode_next = MODE_WAITING;
    endcase

    result_next.conveyor_on       = conveyor_reg_next;
    result_next.compressor_on     = compressor_reg_next;
    result_next.eject_white       = ew;
    result_next.eject_red         = er;
    result_next.eject_blue        = eb;
    result_next.robot_white_ready = ~sample.white_slot_level;
    result_next.robot_red_ready   = ~sample.red_slot_level;
    result_next.robot_blue_ready  = ~sample.blue_slot_level;
    result_next.phase             = mode_next;
  end

endmodule

FILE: bench/csl_checker.sv
// Scoreboard for the color sorting line controller: tracks line state and checks every result.
module csl_checker
  import csl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                sample_stall,
  input  sample_t             sample,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_t             result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending,
  output mode_t               line_mode
);

  cfg_t              line_cfg;
  mode_t             mode;
  logic [ColorW-1:0] min_color;
  logic [DistW-1:0]  target_distance;
  logic [DistW-1:0]  edges_counted;
  part_class_t       part_class;
  logic              prev_key;
  logic [TicksW-1:0] eject_timer;
  logic              conveyor;
  logic              compressor;

  result_t           line_outputs_q[$];
  int                results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    line_mode    = MODE_WAITING;
  end

  task automatic note_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
    end
  endtask

  // One control tick of the line; updates the tracked state.
  function automatic result_t advance_line(sample_t s);
    result_t r;
    r = '0;
    case (mode)
      MODE_WAITING: begin
        if (!s.inlet_barrier_level) begin
          mode      = MODE_SENSING;
          conveyor  = 1'b1;
          min_color = COLOR_START;
        end
      end
      MODE_SENSING: begin
        if (s.color_sample < min_color) min_color = s.color_sample;
        if (!s.outlet_barrier_level) begin
          mode          = MODE_MOVE;
          edges_counted = '0;
          if (min_color < line_cfg.white_threshold) begin
            target_distance = line_cfg.white_distance;
            part_class      = CLASS_WHITE;
          end else if (min_color < line_cfg.red_threshold) begin
            target_distance = line_cfg.red_distance;
            part_class      = CLASS_RED;
          end else begin
            target_distance = line_cfg.blue_distance;
            part_class      = CLASS_BLUE;
          end
          compressor = 1'b1;
        end
      end
      MODE_MOVE: begin
        if (s.pulse_key_level && !prev_key && edges_counted != EDGE_MAX)
          edges_counted = edges_counted + 1'b1;
        prev_key = s.pulse_key_level;
        if (edges_counted >= target_distance) begin
          mode        = MODE_EJECT;
          conveyor    = 1'b0;
          eject_timer = '0;
        end
      end
      default: begin
        case (part_class)
          CLASS_WHITE: r.eject_white = 1'b1;
          CLASS_RED:   r.eject_red   = 1'b1;
          default:     r.eject_blue  = 1'b1;
        endcase
        eject_timer = eject_timer + 1'b1;
        // a zero hold acts like one tick; a wrapped timer also ends the hold
        if (eject_timer == '0 || eject_timer >= line_cfg.eject_ticks) begin
          mode        = MODE_WAITING;
          eject_timer = '0;
        end
      end
    endcase
    r.conveyor_on       = conveyor;
    r.compressor_on     = compressor;
    r.robot_white_ready = ~s.white_slot_level;
    r.robot_red_ready   = ~s.red_slot_level;
    r.robot_blue_ready  = ~s.blue_slot_level;
    r.phase             = mode;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      line_cfg.white_threshold = WHITE_THRESHOLD_RST;
      line_cfg.red_threshold   = RED_THRESHOLD_RST;
      line_cfg.white_distance  = WHITE_DISTANCE_RST;
      line_cfg.red_distance    = RED_DISTANCE_RST;
      line_cfg.blue_distance   = BLUE_DISTANCE_RST;
      line_cfg.eject_ticks     = EJECT_TICKS_RST;
      mode            = MODE_WAITING;
      min_color       = COLOR_START;
      target_distance = '0;
      edges_counted   = '0;
      part_class      = CLASS_BLUE;
      prev_key        = 1'b0;
      eject_timer     = '0;
      conveyor        = 1'b0;
      compressor      = 1'b0;
      line_outputs_q.delete();
    end else begin
      // check the outgoing item before queueing the one coming in at this edge
      if (result_valid && !result_stall) begin
        results_seen++;
        if (line_outputs_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = line_outputs_q.pop_front();
          note_field("conveyor_on", want.conveyor_on, result.conveyor_on);
          note_field("compressor_on", want.compressor_on, result.compressor_on);
          note_field("eject_white", want.eject_white, result.eject_white);
          note_field("eject_red", want.eject_red, result.eject_red);
          note_field("eject_blue", want.eject_blue, result.eject_blue);
          note_field("robot_white_ready", want.robot_white_ready, result.robot_white_ready);
          note_field("robot_red_ready", want.robot_red_ready, result.robot_red_ready);
          note_field("robot_blue_ready", want.robot_blue_ready, result.robot_blue_ready);
          note_field("phase", want.phase, result.phase);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WHITE_THRESHOLD: line_cfg.white_threshold = cfg_data[ColorW-1:0];
          CFG_RED_THRESHOLD:   line_cfg.red_threshold   = cfg_data[ColorW-1:0];
          CFG_WHITE_DISTANCE:  line_cfg.white_distance  = cfg_data[DistW-1:0];
          CFG_RED_DISTANCE:    line_cfg.red_distance    = cfg_data[DistW-1:0];
          CFG_BLUE_DISTANCE:   line_cfg.blue_distance   = cfg_data[DistW-1:0];
          CFG_EJECT_TICKS:     line_cfg.eject_ticks     = cfg_data[TicksW-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall)
        line_outputs_q.push_back(advance_line(sample));
    end
    pending   = line_outputs_q.size();
    line_mode = mode;
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the color sorting line controller: clock, reset, stimulus and verdict.
module tb_top;
  import csl_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int JamCycles   = 300;
  localparam int RandomItems = 1350;
  localparam int PhaseItems  = 120;
  localparam int ColorMax    = 16383;
  localparam int LongHold    = 64;

  // indexes past the register list; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  logic                clk;
  logic                rst;
  logic                sample_valid;
  logic                sample_stall;
  sample_t             sample;
  logic                result_valid;
  logic                result_stall;
  result_t             result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int    fail_count;
  int    pending;
  mode_t line_mode;

  int    cycle_count = 0;
  int    random_sent = 0;
  int    jams_asked = 0;
  int    jams_taken = 0;
  bit    quiet = 1'b0;
  bit    send_calm = 1'b0;
  bit    recv_calm = 1'b0;
  int    white_thr = 2500;
  int    red_thr = 4600;

  color_sorting_line_controller dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  csl_checker line_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .line_mode    (line_mode)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("color_sorting_line_controller test failed");
      $finish;
    end
  end

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin : take_results
    int unsigned hold;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      hold = (quiet || recv_calm) ? 0 : $urandom_range(0, 12);
      if (jams_asked > jams_taken) begin
        hold += JamCycles;
        jams_taken++;
      end
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  function automatic sample_t make_sample(logic inlet, logic outlet, logic key,
                                          logic [ColorW-1:0] color, logic [2:0] slots);
    sample_t s;
    s.inlet_barrier_level  = inlet;
    s.outlet_barrier_level = outlet;
    s.pulse_key_level      = key;
    s.color_sample         = color;
    {s.white_slot_level, s.red_slot_level, s.blue_slot_level} = slots;
    return s;
  endfunction

  // Offer one item after a random gap; return at the falling edge after it is taken.
  task automatic send_item(input sample_t s);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = (quiet || send_calm) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write all six registers; upper data bits beyond a register's width are junk.
  task automatic program_line(input int wt, input int rt, input int wd, input int rd,
                              input int bd, input int et);
    write_reg(CFG_WHITE_THRESHOLD, {2'($urandom), 14'(wt)});
    write_reg(CFG_RED_THRESHOLD, {2'($urandom), 14'(rt)});
    write_reg(CFG_WHITE_DISTANCE, {11'($urandom), 5'(wd)});
    write_reg(CFG_RED_DISTANCE, {11'($urandom), 5'(rd)});
    write_reg(CFG_BLUE_DISTANCE, {11'($urandom), 5'(bd)});
    write_reg(CFG_EJECT_TICKS, 16'(et));
    if ($urandom_range(0, 2) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    cfg_valid <= 1'b0;
    white_thr = wt & ColorMax;
    red_thr   = rt & ColorMax;
  endtask

  // Drop valid and wait until every result is out.
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [ColorW-1:0] pick_color();
    int v;
    case ($urandom_range(0, 5))
      0:       v = white_thr + int'($urandom_range(0, 4)) - 2;
      1:       v = red_thr + int'($urandom_range(0, 4)) - 2;
      2:       v = ($urandom_range(0, 1) != 0) ? ColorMax : 0;
      3:       v = int'(COLOR_START) - int'($urandom_range(0, 1));
      4:       v = $urandom_range(0, ColorMax);
      default: v = $urandom_range(0, int'(COLOR_START));
    endcase
    if (v < 0) v = 0;
    if (v > ColorMax) v = ColorMax;
    return v[ColorW-1:0];
  endfunction

  // Drive one part through the line: mostly well-formed control bits, some noise.
  task automatic run_part();
    sample_t s;
    logic    last_key;
    bit      left_waiting;
    last_key     = 1'b0;
    left_waiting = 1'b0;
    do begin
      s = make_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), pick_color(), 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 11) != 0) begin
        case (line_mode)
          MODE_WAITING: s.inlet_barrier_level  = ($urandom_range(0, 2) == 0);
          MODE_SENSING: s.outlet_barrier_level = ($urandom_range(0, 3) != 0);
          MODE_MOVE:    if ($urandom_range(0, 4) != 0) s.pulse_key_level = !last_key;
          default: ;
        endcase
      end
      last_key = s.pulse_key_level;
      send_item(s);
      random_sent++;
      if (line_mode != MODE_WAITING) left_waiting = 1'b1;
    end while (!(left_waiting && line_mode == MODE_WAITING));
  endtask

  initial begin : make_stimulus
    int          phase_no;
    int          phase_end;
    int unsigned et;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // white part with default thresholds and distance, short hold
    write_reg(CFG_EJECT_TICKS, 16'd2);
    cfg_valid <= 1'b0;
    send_item(make_sample(1'b1, 1'b0, 1'b1, 14'h3FFF, 3'b111));
    send_item(make_sample(1'b0, 1'b1, 1'b0, 14'h3FFF, 3'b000));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'h3FFF, 3'b101));
    send_item(make_sample(1'b1, 1'b0, 1'b0, 14'd2499, 3'b010));
    send_item(make_sample(1'b0, 1'b1, 1'b1, 14'd0, 3'b111));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'd0, 3'b000));
    send_item(make_sample(1'b1, 1'b1, 1'b1, 14'd0, 3'b110));
    send_item(make_sample(1'b1, 1'b1, 1'b1, 14'd0, 3'b001));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'd0, 3'b011));
    send_item(make_sample(1'b1, 1'b1, 1'b1, 14'd0, 3'b100));
    send_item(make_sample(1'b0, 1'b0, 1'b1, 14'h3FFF, 3'b000));
    send_item(make_sample(1'b0, 1'b0, 1'b0, 14'h3FFF, 3'b111));
    settle();

    // thresholds in wrong order, zero white and blue distances, zero hold
    program_line(9000, 100, 0, 1, 0, 0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0001);
    cfg_valid <= 1'b0;
    send_item(make_sample(1'b0, 1'b1, 1'b0, 14'd8000, 3'b111));
    send_item(make_sample(1'b0, 1'b0, 1'b0, 14'd5000, 3'b000));
    send_item(make_sample(1'b0, 1'b1, 1'b0, 14'd0, 3'b111));
    send_item(make_sample(1'b1, 1'b1, 1'b1, 14'd0, 3'b000));
    send_item(make_sample(1'b0, 1'b1, 1'b0, 14'd0, 3'b101));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'd9500, 3'b010));
    send_item(make_sample(1'b1, 1'b0, 1'b0, 14'd12000, 3'b111));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'd0, 3'b000));
    send_item(make_sample(1'b1, 1'b1, 1'b0, 14'd0, 3'b110));
    settle();

    // random parts in phases of fresh settings; first two phases at the extremes
    jams_asked++;
    phase_no = 0;
    while (random_sent < RandomItems) begin
      settle();
      case (phase_no)
        0: program_line(ColorMax, ColorMax, 31, 31, 31, 1);
        1: program_line(0, 0, 0, 0, 0, 3);
        default: begin
          et = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          program_line($urandom_range(0, 9000), $urandom_range(0, 11000),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 12),
                       et);
        end
      endcase
      phase_end = random_sent + PhaseItems;
      while (random_sent < phase_end) run_part();
      phase_no++;
    end

    // long hold, run back to back
    settle();
    quiet = 1'b1;
    program_line($urandom_range(0, 9000), $urandom_range(0, 11000), 2, 3, 4, LongHold);
    run_part();
    quiet = 1'b0;

    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("color_sorting_line_controller test passed");
    else
      $display("color_sorting_line_controller test failed");
    $finish;
  end

endmodule
